FILE: rtl/fixed_point_17_14_alu_top_assert.svh
// Assertion macros for the fixed-point ALU.
// Used by fixed_point_17_14_alu_top.sv; expects a clk and a rst in scope.
`ifndef FIXED_POINT_17_14_ALU_TOP_ASSERT_SVH
`define FIXED_POINT_17_14_ALU_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FXALU_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, checked outside reset
`define FXALU_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/fxalu_pkg.sv
// Shared constants, codes, types and helpers for the fixed-point ALU.
// No dependencies; imported by fxalu_div and fixed_point_17_14_alu_top.
package fxalu_pkg;

  localparam int FRACTION_BITS = 14;
  localparam int WORD_BITS     = 32;
  localparam int INT_BITS      = WORD_BITS - 1 - FRACTION_BITS;
  // dividend magnitude width: a shifted left by the fraction bits
  localparam int DIV_WIDTH     = WORD_BITS + FRACTION_BITS;
  localparam int DIV_STEPS     = 8;
  localparam int DIV_STAGES    = (DIV_WIDTH + DIV_STEPS - 1) / DIV_STEPS;

  typedef enum logic [3:0] {
    OP_TO_FIXED     = 4'd0,
    OP_TO_INT_TRUNC = 4'd1,
    OP_TO_INT_NEAR  = 4'd2,
    OP_ADD          = 4'd3,
    OP_ADD_INT      = 4'd4,
    OP_SUB          = 4'd5,
    OP_SUB_INT      = 4'd6,
    OP_MUL          = 4'd7,
    OP_MUL_INT      = 4'd8,
    OP_DIV          = 4'd9,
    OP_DIV_INT      = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  // data that rides alongside the divider
  typedef struct packed {
    logic                   is_div;
    logic                   qneg;
    logic [WORD_BITS-1:0]   res;
    status_t                st;
  } side_t;

  // integer to fixed: {out_of_range, fixed value}
  function automatic logic [WORD_BITS:0] to_fixed(logic [WORD_BITS-1:0] v);
    logic bad;
    logic [WORD_BITS-1:0] fx;
    bad = !((&v[WORD_BITS-1:INT_BITS]) || (~|v[WORD_BITS-1:INT_BITS]));
    fx  = bad ? '1 : (v << FRACTION_BITS);
    return {bad, fx};
  endfunction

endpackage

FILE: rtl/fixed_point_17_14_alu_top.sv
// Signed Q17.14 fixed-point ALU, top level.
// Depends on fxalu_pkg, fxalu_div and fixed_point_17_14_alu_top_assert.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  request | req_valid, req_stall | op, operand_a, operand_b
//  respond | rsp_valid, rsp_stall | result, status
//
// Every op passes through stage 0 and then the DIV_STAGES divider stages:
// 46 shift-subtract steps, 8 per stage. One transfer per cycle unless
// req_stall is high. The whole pipeline freezes while a result waits under
// rsp_stall; req_stall is high exactly then. Reset empties the pipeline.
module fixed_point_17_14_alu_top
  import fxalu_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [3:0]                  op,
  input  logic signed [WORD_BITS-1:0] operand_a,
  input  logic signed [WORD_BITS-1:0] operand_b,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic signed [WORD_BITS-1:0] result,
  output logic [1:0]                  status
);

  `include "fixed_point_17_14_alu_top_assert.svh"

  localparam int W34 = WORD_BITS + 2;
  localparam logic signed [W34-1:0] HALF  = W34'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [W34-1:0] ROUND = (W34'(1) <<< FRACTION_BITS) - W34'(1);

  logic advance;

  // stage 0 registers
  logic                          s0_valid;
  logic                          s0_mul;
  logic                          s0_mul_int;
  side_t                         s0_side;
  logic signed [2*WORD_BITS-1:0] s0_prod;
  logic [DIV_WIDTH-1:0]          s0_nmag;
  logic [WORD_BITS-1:0]          s0_dmag;

  side_t                side_c;
  logic [DIV_WIDTH-1:0] nmag_c;
  logic [WORD_BITS-1:0] dmag_c;

  side_t                div_side_in;
  logic                 div_valid;
  side_t                div_side;
  logic [DIV_WIDTH-1:0] div_quot;
  logic [WORD_BITS-1:0] qlo;

  assign advance   = !(rsp_valid && rsp_stall);
  assign req_stall = !advance;

  // decode, and the results of the ops other than multiply and divide
  always_comb begin
    logic [WORD_BITS:0]          fx;
    logic signed [WORD_BITS-1:0] t32;
    logic signed [W34-1:0]       t34;
    logic signed [DIV_WIDTH-1:0] nval;
    fx  = '0;
    t32 = '0;
    t34 = '0;
    side_c = '{is_div: 1'b0, qneg: operand_a[WORD_BITS-1] ^ operand_b[WORD_BITS-1],
               res: '0, st: ST_OK};
    unique case (op_t'(op)) inside
      OP_TO_FIXED: begin
        fx = to_fixed(operand_a);
        side_c.res = fx[WORD_BITS-1:0];
        side_c.st  = fx[WORD_BITS] ? ST_RANGE : ST_OK;
      end
      OP_TO_INT_TRUNC: begin
        t32 = operand_a + (operand_a[WORD_BITS-1] ? WORD_BITS'(ROUND) : '0);
        side_c.res = t32 >>> FRACTION_BITS;
      end
      OP_TO_INT_NEAR: begin
        t34 = {{2{operand_a[WORD_BITS-1]}}, operand_a};
        if (operand_a > 0) t34 = t34 + HALF;
        else               t34 = t34 - HALF + ROUND;
        side_c.res = WORD_BITS'(t34 >>> FRACTION_BITS);
      end
      OP_ADD: side_c.res = operand_a + operand_b;
      OP_ADD_INT: begin
        fx = to_fixed(operand_b);
        side_c.res = operand_a + fx[WORD_BITS-1:0];
        side_c.st  = fx[WORD_BITS] ? ST_RANGE : ST_OK;
      end
      OP_SUB: side_c.res = operand_a - operand_b;
      OP_SUB_INT: begin
        fx = to_fixed(-operand_b);
        side_c.res = operand_a + fx[WORD_BITS-1:0];
        side_c.st  = fx[WORD_BITS] ? ST_RANGE : ST_OK;
      end
      OP_DIV, OP_DIV_INT: begin
        if (operand_b == '0) side_c.st = ST_DIV_ZERO;
        else                 side_c.is_div = 1'b1;
      end
      default: ;
    endcase

    // divider operands as magnitudes
    if (op_t'(op) == OP_DIV) nval = {operand_a, {FRACTION_BITS{1'b0}}};
    else nval = {{FRACTION_BITS{operand_a[WORD_BITS-1]}}, operand_a};
    nmag_c = nval[DIV_WIDTH-1] ? -nval : nval;
    dmag_c = operand_b[WORD_BITS-1] ? -operand_b : operand_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_mul     <= (op_t'(op) == OP_MUL);
      s0_mul_int <= (op_t'(op) == OP_MUL_INT);
      s0_side    <= side_c;
      s0_prod    <= operand_a * operand_b;
      s0_nmag    <= nmag_c;
      s0_dmag    <= dmag_c;
    end
  end

  // finish the multiplies from the registered product
  always_comb begin
    div_side_in = s0_side;
    if (s0_mul)     div_side_in.res = s0_prod[FRACTION_BITS+WORD_BITS-1:FRACTION_BITS];
    if (s0_mul_int) div_side_in.res = s0_prod[WORD_BITS-1:0];
  end

  fxalu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s0_valid),
    .in_side   (div_side_in),
    .in_num    (s0_nmag),
    .in_den    (s0_dmag),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_quot  (div_quot)
  );

  // apply quotient sign, wrap to 32 bits
  assign qlo       = div_quot[WORD_BITS-1:0];
  assign rsp_valid = div_valid;
  assign result    = div_side.is_div ? (div_side.qneg ? -qlo : qlo) : div_side.res;
  assign status    = div_side.st;

  `FXALU_ASSERT_NOW(a_dz_zero, rsp_valid && status == ST_DIV_ZERO, result == '0, "div by zero result not 0")
  `FXALU_ASSERT_NOW(a_status_code, rsp_valid, status != 2'd3, "status code 3 produced")
  `FXALU_ASSERT_NEXT(a_freeze, rsp_valid && rsp_stall, $stable(s0_valid) && $stable(s0_side), "front stage moved under stall")
  `FXALU_ASSERT_NOW(a_div_ok, rsp_valid && div_side.is_div, status == ST_OK, "divide flagged with bad status")

endmodule

FILE: rtl/fxalu_div.sv
// Pipelined restoring divider for unsigned magnitudes, DIV_STEPS steps per stage.
// Depends on fxalu_pkg; the side payload travels with each quotient.
module fxalu_div
  import fxalu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   in_valid,
  input  side_t                  in_side,
  input  logic [DIV_WIDTH-1:0]   in_num,
  input  logic [WORD_BITS-1:0]   in_den,
  output logic                   out_valid,
  output side_t                  out_side,
  output logic [DIV_WIDTH-1:0]   out_quot
);

  logic                 vld  [DIV_STAGES];
  side_t                side [DIV_STAGES];
  logic [WORD_BITS-1:0] rem  [DIV_STAGES];
  logic [DIV_WIDTH-1:0] quo  [DIV_STAGES];
  logic [WORD_BITS-1:0] den  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic                 p_vld;
    side_t                p_side;
    logic [WORD_BITS-1:0] p_rem;
    logic [DIV_WIDTH-1:0] p_quo;
    logic [WORD_BITS-1:0] p_den;
    logic [WORD_BITS-1:0] rem_next;
    logic [DIV_WIDTH-1:0] quo_next;

    if (k == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_side = in_side;
      assign p_rem  = '0;
      assign p_quo  = in_num;
      assign p_den  = in_den;
    end else begin : g_rest
      assign p_vld  = vld[k-1];
      assign p_side = side[k-1];
      assign p_rem  = rem[k-1];
      assign p_quo  = quo[k-1];
      assign p_den  = den[k-1];
    end

    // shift-subtract steps of this stage
    always_comb begin
      logic [WORD_BITS:0] t;
      rem_next = p_rem;
      quo_next = p_quo;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (k * DIV_STEPS + j < DIV_WIDTH) begin
          t = {rem_next, quo_next[DIV_WIDTH-1]};
          quo_next = {quo_next[DIV_WIDTH-2:0], 1'b0};
          if (t >= {1'b0, p_den}) begin
            t = t - {1'b0, p_den};
            quo_next[0] = 1'b1;
          end
          rem_next = t[WORD_BITS-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (advance) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        side[k] <= p_side;
        rem[k]  <= rem_next;
        quo[k]  <= quo_next;
        den[k]  <= p_den;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_side  = side[DIV_STAGES-1];
  assign out_quot  = quo[DIV_STAGES-1];

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the Q17.14 fixed-point ALU top level.
// Depends on fxalu_pkg and fixed_point_17_14_alu_top; compares each response with a
// behavioral prediction computed when the request transfer is accepted.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fxalu_pkg::*;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } req_t;

  typedef struct {
    logic [31:0] result;
    logic [1:0]  status;
  } rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [3:0]  op = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic signed [31:0] result;
  logic [1:0]  status;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   error_count = 0;
  int   cycle_count = 0;
  int   calm_start, calm_stop;
  int   hold_start;
  int   hold_len = 300;
  bit   hold_on = 1'b0;

  fixed_point_17_14_alu_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .op(op), .operand_a(operand_a), .operand_b(operand_b),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .result(result), .status(status)
  );

  always #5 clk = ~clk;

  // integer to fixed with range check
  function automatic logic [31:0] int_to_fx(longint v, ref bit bad);
    longint hi, lo;
    hi = (longint'(1) <<< INT_BITS) - 1;
    lo = -(longint'(1) <<< INT_BITS);
    if (v > hi || v < lo) begin
      bad = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return 32'(v <<< FRACTION_BITS);
  endfunction

  // arithmetic predictor
  function automatic rsp_t alu_predict(req_t r);
    rsp_t   o;
    longint a, b, one, half, p, n;
    bit     bad;
    a = longint'($signed(r.a));
    b = longint'($signed(r.b));
    one = longint'(1) <<< FRACTION_BITS;
    half = one / 2;
    bad = 1'b0;
    o.result = '0;
    o.status = ST_OK;
    case (r.op)
      OP_TO_FIXED:     o.result = int_to_fx(a, bad);
      OP_TO_INT_TRUNC: o.result = 32'(a / one);
      OP_TO_INT_NEAR: begin
        if (a > 0) o.result = 32'((a + half) / one);
        else o.result = 32'((a - half) / one);
      end
      OP_ADD:     o.result = r.a + r.b;
      OP_ADD_INT: o.result = r.a + int_to_fx(b, bad);
      OP_SUB:     o.result = r.a - r.b;
      OP_SUB_INT: o.result = r.a + int_to_fx(longint'($signed(32'(0) - r.b)), bad);
      OP_MUL: begin
        p = a * b;
        o.result = 32'(p >>> FRACTION_BITS);
      end
      OP_MUL_INT: o.result = r.a * r.b;
      OP_DIV: begin
        if (b == 0) o.status = ST_DIV_ZERO;
        else begin
          n = a <<< FRACTION_BITS;
          o.result = 32'(n / b);
        end
      end
      OP_DIV_INT: begin
        if (b == 0) o.status = ST_DIV_ZERO;
        else o.result = 32'(a / b);
      end
      default: ;
    endcase
    if (bad) o.status = ST_RANGE;
    return o;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      1: return 32'($signed($urandom_range(0, 64)) - 32);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return 32'($urandom_range(0, 7)) << 14;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(logic [3:0] o, logic [31:0] a, logic [31:0] b);
    req_t r;
    r.op = o; r.a = a; r.b = b;
    pending_reqs.push_back(r);
  endtask

  // idle control: quiet window with no idling, random idling otherwise
  function automatic bit idle_now();
    if (cycle_count >= calm_start && cycle_count < calm_stop) return 1'b0;
    return $urandom_range(0, 99) < 24;
  endfunction

  // request driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() > 0 && !idle_now()) begin
          req_t r;
          r = pending_reqs.pop_front();
          req_valid <= 1'b1;
          op <= r.op;
          operand_a <= r.a;
          operand_b <= r.b;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // prediction on each accepted request transfer
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) begin
      req_t r;
      r.op = op; r.a = operand_a; r.b = operand_b;
      expected_rsps.push_back(alu_predict(r));
    end
  end

  // long receiver hold-off, counted in cycles here
  initial begin
    wait (!rst);
    repeat (hold_start) @(posedge clk);
    hold_on <= 1'b1;
    repeat (hold_len) @(posedge clk);
    hold_on <= 1'b0;
  end

  // response monitor and receiver stall
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response result=%h status=%0d", result, status);
        error_count++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (result !== e.result) begin
          $error("result expected %h actual %h", e.result, result);
          error_count++;
        end
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          error_count++;
        end
      end
    end
    if (hold_on)
      rsp_stall <= 1'b1;
    else
      rsp_stall <= idle_now();
  end

  // stimulus
  initial begin
    logic [31:0] edges[8];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1,
              32'h0001_FFFF, 32'hFFFE_0000, 32'h0002_0000};
    calm_start = 500; calm_stop = 1100;
    hold_start = 1500;
    // directed: every op, range edges, rounding halves, divide by zero
    push_req(OP_TO_FIXED, 32'h0001_FFFF, 0);
    push_req(OP_TO_FIXED, 32'hFFFE_0000, 0);
    push_req(OP_TO_FIXED, 32'h0002_0000, 0);
    push_req(OP_TO_FIXED, 32'hFFFD_FFFF, 0);
    push_req(OP_TO_INT_TRUNC, 32'hFFFF_C001, 0);
    push_req(OP_TO_INT_NEAR, 32'h0000_6000, 0);
    push_req(OP_TO_INT_NEAR, 32'hFFFF_A000, 0);
    push_req(OP_TO_INT_NEAR, 32'h7FFF_FFFF, 0);
    push_req(OP_TO_INT_NEAR, 32'h8000_0000, 0);
    push_req(OP_ADD, 32'h7FFF_FFFF, 32'h1);
    push_req(OP_ADD_INT, 32'h4000, 32'h0002_0000);
    push_req(OP_SUB, 32'h8000_0000, 32'h1);
    push_req(OP_SUB_INT, 32'h4000, 32'h8000_0000);
    push_req(OP_SUB_INT, 32'h4000, 32'hFFFE_0000);
    push_req(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    push_req(OP_MUL, 32'hFFFF_FFFF, 32'h1);
    push_req(OP_MUL_INT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_req(OP_DIV, 32'h4000, 32'h0);
    push_req(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    push_req(OP_DIV, 32'h7FFF_FFFF, 32'h1);
    push_req(OP_DIV_INT, 32'h8000_0000, 32'hFFFF_FFFF);
    push_req(OP_DIV_INT, 32'h5, 32'h0);
    push_req(OP_DIV_INT, 32'hFFFF_FFF9, 32'h2);
    push_req(4'd11, 32'h1234, 32'h5678);
    push_req(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // random mix, mostly legal ops
    for (int i = 0; i < 1850; i++) begin
      logic [3:0]  o;
      logic [31:0] a, b;
      o = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                       : 4'($urandom_range(0, 10));
      a = ($urandom_range(0, 9) == 0) ? edges[$urandom_range(0, 7)] : rand_operand();
      b = ($urandom_range(0, 9) == 0) ? edges[$urandom_range(0, 7)] : rand_operand();
      push_req(o, a, b);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !req_valid);
    wait (expected_rsps.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/fxalu_pkg.sv
rtl/fxalu_div.sv
rtl/fixed_point_17_14_alu_top.sv
tb/sv/testbench.sv
